// File: rtl/rwss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwss_pkg
// Types and constants shared by the raycast wall slice setup pipeline.
// ----------------------------------------------------------------------------
package rwss_pkg;

    localparam int SCREEN_ROWS = 512;
    localparam int TEX_COLS    = 64;
    localparam int TEX_ROWS    = 64;

    localparam int HALF_ROWS   = SCREEN_ROWS / 2;
    localparam int HEIGHT_MAX  = 134217727;
    localparam int H_NUM       = SCREEN_ROWS * 65536;
    localparam int S_NUM       = TEX_ROWS * 65536;

    localparam int H_NUM_W     = $clog2(H_NUM + 1);
    localparam int S_NUM_W     = $clog2(S_NUM + 1);
    localparam int DIV_NW      = (H_NUM_W > S_NUM_W) ? H_NUM_W : S_NUM_W;
    localparam int DIV_BPS     = 4;
    localparam int DIV_ST      = (DIV_NW + DIV_BPS - 1) / DIV_BPS;
    localparam int DIV_PW      = DIV_ST * DIV_BPS;

    localparam int PIPE_LEN    = 2 * DIV_ST + 7;

    typedef struct packed {
        logic [1:0]         hit_side;
        logic [31:0]        side_dist_x;
        logic [31:0]        side_dist_y;
        logic [31:0]        delta_dist_x;
        logic [31:0]        delta_dist_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic [31:0]        player_x;
        logic [31:0]        player_y;
        logic [11:0]        column_in;
    } t_in_item;

    typedef struct packed {
        logic [11:0] column_out;
        logic [1:0]  side_out;
        logic [26:0] slice_height;
        logic [10:0] first_row;
        logic [10:0] stop_row;
        logic [9:0]  tex_column;
        logic [31:0] tex_step;
        logic [31:0] tex_start;
    } t_out_item;

    typedef struct packed {
        logic [11:0] col;
        logic [1:0]  side;
        logic [9:0]  tx;
    } t_sb1;

    typedef struct packed {
        logic [11:0] col;
        logic [1:0]  side;
        logic [9:0]  tx;
        logic [26:0] h;
        logic [10:0] first;
        logic [10:0] stop;
        logic [25:0] off;
        logic        hz;
    } t_sb2;

endpackage
`default_nettype wire

// File: rtl/rwss_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwss_in_if / rwss_out_if
// Valid/ready channels for column items and slice results.
// ----------------------------------------------------------------------------
interface rwss_in_if import rwss_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rwss_out_if import rwss_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rwss_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwss_div
// Pipelined restoring divider, DIV_BPS (four) quotient bits per stage.
// ----------------------------------------------------------------------------
module rwss_div import rwss_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [DIV_PW-1:0] i_num,
    input  wire logic [31:0]       i_den,
    output logic      [DIV_PW-1:0] o_quo
);

    logic [DIV_PW-1:0] r_w   [DIV_ST];
    logic [31:0]       r_rem [DIV_ST];
    logic [31:0]       r_den [DIV_ST];
    logic [DIV_PW-1:0] n_w   [DIV_ST];
    logic [31:0]       n_rem [DIV_ST];
    logic [31:0]       n_den [DIV_ST];

    always_comb begin
        logic [DIV_PW-1:0] w;
        logic [32:0]       rem;
        logic [31:0]       den;
        for (int s = 0; s < DIV_ST; s++) begin
            if (s == 0) begin
                w   = i_num;
                rem = 33'd0;
                den = i_den;
            end else begin
                w   = r_w[s-1];
                rem = {1'b0, r_rem[s-1]};
                den = r_den[s-1];
            end
            for (int b = 0; b < DIV_BPS; b++) begin
                rem = {rem[31:0], w[DIV_PW-1]};
                w   = {w[DIV_PW-2:0], 1'b0};
                if (rem >= {1'b0, den}) begin
                    rem  = rem - {1'b0, den};
                    w[0] = 1'b1;
                end
            end
            n_w[s]   = w;
            n_rem[s] = rem[31:0];
            n_den[s] = den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w   <= n_w;
            r_rem <= n_rem;
            r_den <= n_den;
        end
    end

    assign o_quo = r_w[DIV_ST-1];

endmodule
`default_nettype wire

// File: rtl/raycast_wall_slice_setup_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// raycast_wall_slice_setup_core
// Per-column wall slice setup for a textured grid raycaster.
// ----------------------------------------------------------------------------
// One column item enters on i_in_ch and one slice result leaves on o_out_ch;
// both are valid/ready channels and a transfer happens when both are high.
// Throughput is one column per cycle while the receiver takes results. The
// pipeline runs through three setup stages, the height divider, a
// clamp stage, the texture step divider, and step, product and output stages.
// The two dividers resolve four quotient bits per stage, which sets the depth.
// The whole pipeline advances together; when the receiver holds ready low
// with a result waiting, every stage holds and i_in_ch.ready drops, so no
// item is lost or repeated. Empty slots move on while a result waits only
// after it is taken. Synchronous active-low reset clears all valid bits; data
// registers are not reset. There are no configuration registers.
// ----------------------------------------------------------------------------
module raycast_wall_slice_setup_core import rwss_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rwss_in_if.sink      i_in_ch,
    rwss_out_if.source   o_out_ch
);

    logic                en;
    logic [PIPE_LEN-1:0] r_vld;

    assign en             = !r_vld[PIPE_LEN-1] || o_out_ch.ready;
    assign i_in_ch.ready  = en;
    assign o_out_ch.valid = r_vld[PIPE_LEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LEN-2:0], i_in_ch.valid};
        end
    end

    // stage 1: distance and selection
    t_in_item    d;
    logic        xside;
    logic [31:0] sd, dd, n1_dist;
    logic [15:0] r1_pos;
    logic [31:0] r1_dist, r1_dir;
    logic        r1_mirror;
    logic [11:0] r1_col;
    logic [1:0]  r1_side;

    assign d       = i_in_ch.data;
    assign xside   = !d.hit_side[0];
    assign sd      = xside ? d.side_dist_x : d.side_dist_y;
    assign dd      = xside ? d.delta_dist_x : d.delta_dist_y;
    assign n1_dist = (sd > dd) ? (sd - dd) : 32'd1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dist   <= n1_dist;
            r1_pos    <= xside ? d.player_y[15:0] : d.player_x[15:0];
            r1_dir    <= xside ? d.dir_y : d.dir_x;
            r1_mirror <= xside ? (!d.dir_x[31] && (d.dir_x != 32'sd0)) : d.dir_y[31];
            r1_col    <= d.column_in;
            r1_side   <= d.hit_side;
        end
    end

    // stage 2: wall fraction
    logic [31:0] wprod;
    logic [31:0] r2_frac, r2_dist;
    logic        r2_mirror;
    logic [11:0] r2_col;
    logic [1:0]  r2_side;

    assign wprod = r1_dist * r1_dir;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_frac   <= {r1_pos, 16'd0} + wprod;
            r2_dist   <= r1_dist;
            r2_mirror <= r1_mirror;
            r2_col    <= r1_col;
            r2_side   <= r1_side;
        end
    end

    // stage 3: texture column
    logic [63:0] cprod;
    logic [9:0]  tx_raw;
    logic [31:0] r3_dist;
    t_sb1        r3_sb;

    assign cprod  = 64'(r2_frac) * 64'(TEX_COLS);
    assign tx_raw = cprod[41:32];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dist     <= r2_dist;
            r3_sb.col   <= r2_col;
            r3_sb.side  <= r2_side;
            r3_sb.tx    <= r2_mirror ? (10'(TEX_COLS - 1) - tx_raw) : tx_raw;
        end
    end

    // height divider
    logic [DIV_PW-1:0] q1;
    t_sb1              r_sb1 [DIV_ST];

    rwss_div u_div_h (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (DIV_PW'(H_NUM)),
        .i_den (r3_dist),
        .o_quo (q1)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb1[0] <= r3_sb;
            for (int i = 1; i < DIV_ST; i++) r_sb1[i] <= r_sb1[i-1];
        end
    end

    // stage 4: saturate and clamp rows
    logic [26:0] h;
    logic [25:0] hh;
    t_sb2        r4_sb;

    assign h  = (32'(q1) > 32'(HEIGHT_MAX)) ? 27'(HEIGHT_MAX) : 27'(q1);
    assign hh = h[26:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sb.col   <= r_sb1[DIV_ST-1].col;
            r4_sb.side  <= r_sb1[DIV_ST-1].side;
            r4_sb.tx    <= r_sb1[DIV_ST-1].tx;
            r4_sb.h     <= h;
            r4_sb.hz    <= (h == 27'd0);
            r4_sb.first <= (hh >= 26'(HALF_ROWS)) ? 11'd0 : 11'(26'(HALF_ROWS) - hh);
            r4_sb.stop  <= (hh >= 26'(SCREEN_ROWS - HALF_ROWS)) ? 11'(SCREEN_ROWS - 1)
                                                               : 11'(hh + 26'(HALF_ROWS));
            r4_sb.off   <= (hh > 26'(HALF_ROWS)) ? (hh - 26'(HALF_ROWS)) : 26'd0;
        end
    end

    // texture step divider
    logic [DIV_PW-1:0] q2;
    t_sb2              r_sb2 [DIV_ST];

    rwss_div u_div_s (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (DIV_PW'(S_NUM)),
        .i_den ({5'd0, r4_sb.h}),
        .o_quo (q2)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb2[0] <= r4_sb;
            for (int i = 1; i < DIV_ST; i++) r_sb2[i] <= r_sb2[i-1];
        end
    end

    // stage 5: step, stage 6: start product, stage 7: output
    logic [31:0] r5_step, r6_step;
    t_sb2        r5_sb, r6_sb;
    logic [57:0] r6_prod;
    t_out_item   r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sb   <= r_sb2[DIV_ST-1];
            r5_step <= r_sb2[DIV_ST-1].hz ? 32'hFFFF_FFFF : 32'(q2);
            r6_sb   <= r5_sb;
            r6_step <= r5_step;
            r6_prod <= 58'(r5_sb.off) * 58'(r5_step);
            r_out.column_out   <= r6_sb.col;
            r_out.side_out     <= r6_sb.side;
            r_out.slice_height <= r6_sb.h;
            r_out.first_row    <= r6_sb.first;
            r_out.stop_row     <= r6_sb.stop;
            r_out.tex_column   <= r6_sb.tx;
            r_out.tex_step     <= r6_step;
            if (r6_sb.hz) begin
                r_out.tex_start <= 32'd0;
            end else if (r6_prod[57:32] != 26'd0) begin
                r_out.tex_start <= 32'hFFFF_FFFF;
            end else begin
                r_out.tex_start <= r6_prod[31:0];
            end
        end
    end

    assign o_out_ch.data = r_out;

`ifndef SYNTHESIS
    a_zero_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && (o_out_ch.data.slice_height == 27'd0) |->
        (o_out_ch.data.tex_step == 32'hFFFF_FFFF) && (o_out_ch.data.tex_start == 32'd0))
        else $error("zero height slice without saturated step");
    a_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid |-> (32'(o_out_ch.data.first_row) <= 32'(HALF_ROWS)) &&
        (32'(o_out_ch.data.stop_row) < 32'(SCREEN_ROWS)))
        else $error("row bounds outside screen");
    a_texcol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid |-> (32'(o_out_ch.data.tex_column) < 32'(TEX_COLS)))
        else $error("texture column out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

// File: tb/tb_rwss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rwss_if
// Interfaces are supplied with the RTL; this file only gathers the testbench
// side helpers for the channel payloads.
// ----------------------------------------------------------------------------
package tb_rwss_pkg;
    import rwss_pkg::*;

    typedef struct {
        t_in_item  col_item;
        logic      has_slice;
        t_out_item slice;
    } t_col_row;
endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for raycast_wall_slice_setup_core.
// Columns are driven over the valid/ready input channel under several idle and
// stall mixes; every slice result is compared field by field against a slice
// predictor computed in the bench or a fixed slice, oldest expectation first.
// ----------------------------------------------------------------------------
module tb;
    import rwss_pkg::*;
    import tb_rwss_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM    = 830;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rwss_in_if  in_ch ();
    rwss_out_if out_ch ();

    raycast_wall_slice_setup_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch.sink),
        .o_out_ch (out_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_out_item pending_slices[$];
    int        n_errors = 0;
    int        n_slices = 0;
    int        n_cols   = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        quiet_cycles = 0;
    int        n_hzero = 0;

    function automatic t_out_item predict_slice(t_in_item c);
        t_out_item   r;
        logic        xside;
        logic [63:0] sd, dd, wdist, h, pos, dir, wall, frac, tx, step, tst;
        longint      start_r, end_r, off;
        xside = ~c.hit_side[0];
        sd    = xside ? c.side_dist_x : c.side_dist_y;
        dd    = xside ? c.delta_dist_x : c.delta_dist_y;
        wdist = (sd > dd) ? sd - dd : 64'd1;
        h     = (64'(SCREEN_ROWS) << 16) / wdist;
        if (h > 64'(HEIGHT_MAX)) h = 64'(HEIGHT_MAX);
        start_r = longint'(HALF_ROWS) - longint'(h / 2);
        if (start_r < 0) start_r = 0;
        end_r = longint'(h / 2) + longint'(HALF_ROWS);
        if (end_r >= SCREEN_ROWS) end_r = SCREEN_ROWS - 1;
        pos  = xside ? 64'(c.player_y) : 64'(c.player_x);
        dir  = xside ? 64'(signed'(c.dir_y)) : 64'(signed'(c.dir_x));
        wall = (pos << 16) + wdist * dir;
        frac = {32'd0, wall[31:0]};
        tx   = (frac * 64'(TEX_COLS)) >> 32;
        if ((xside && !c.dir_x[31] && c.dir_x != 0) || (!xside && c.dir_y[31]))
            tx = 64'(TEX_COLS) - tx - 64'd1;
        if (h == 0) begin
            step = 64'hFFFF_FFFF;
            tst  = 64'd0;
        end else begin
            off  = start_r - longint'(HALF_ROWS) + longint'(h / 2);
            step = (64'(TEX_ROWS) << 16) / h;
            if (step > 64'hFFFF_FFFF) step = 64'hFFFF_FFFF;
            if (off < 0) off = 0;
            tst = 64'(off) * step;
            if (tst > 64'hFFFF_FFFF) tst = 64'hFFFF_FFFF;
        end
        r.column_out   = c.column_in;
        r.side_out     = c.hit_side;
        r.slice_height = h[26:0];
        r.first_row    = start_r[10:0];
        r.stop_row     = end_r[10:0];
        r.tex_column   = tx[9:0];
        r.tex_step     = step[31:0];
        r.tex_start    = tst[31:0];
        return r;
    endfunction

    function automatic t_in_item make_col(logic [1:0] side, logic [31:0] sdx,
                                          logic [31:0] sdy, logic [31:0] ddx,
                                          logic [31:0] ddy, logic [31:0] dx,
                                          logic [31:0] dy, logic [31:0] px,
                                          logic [31:0] py, logic [11:0] col);
        t_in_item c;
        c.hit_side     = side;
        c.side_dist_x  = sdx;
        c.side_dist_y  = sdy;
        c.delta_dist_x = ddx;
        c.delta_dist_y = ddy;
        c.dir_x        = dx;
        c.dir_y        = dy;
        c.player_x     = px;
        c.player_y     = py;
        c.column_in    = col;
        return c;
    endfunction

    function automatic logic [31:0] rand_dist();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 4);
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(32'h0000_4000, 32'h0040_0000);
        endcase
    endfunction

    function automatic t_in_item rand_col();
        t_in_item c;
        logic [31:0] ddx, ddy;
        ddx = rand_dist();
        ddy = rand_dist();
        c = make_col(2'($urandom_range(0, 3)),
                     ($urandom_range(0, 9) == 0) ? rand_dist() : ddx + rand_dist(),
                     ($urandom_range(0, 9) == 0) ? rand_dist() : ddy + rand_dist(),
                     ddx, ddy,
                     ($urandom_range(0, 3) == 0) ? $urandom() :
                         32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000),
                     ($urandom_range(0, 3) == 0) ? $urandom() :
                         32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000),
                     $urandom(), $urandom(), 12'($urandom_range(0, 4095)));
        return c;
    endfunction

    // receiver: random stalls, compare transfers against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want, got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                n_slices++;
                if (pending_slices.size() == 0) begin
                    $error("result with no expectation: column %0d", got.column_out);
                    n_errors++;
                end else begin
                    want = pending_slices.pop_front();
                    if (got.column_out !== want.column_out) begin
                        $error("column_out exp %0h got %0h", want.column_out, got.column_out);
                        n_errors++;
                    end
                    if (got.side_out !== want.side_out) begin
                        $error("side_out exp %0h got %0h", want.side_out, got.side_out);
                        n_errors++;
                    end
                    if (got.slice_height !== want.slice_height) begin
                        $error("slice_height exp %0h got %0h",
                               want.slice_height, got.slice_height);
                        n_errors++;
                    end
                    if (got.first_row !== want.first_row) begin
                        $error("first_row exp %0h got %0h", want.first_row, got.first_row);
                        n_errors++;
                    end
                    if (got.stop_row !== want.stop_row) begin
                        $error("stop_row exp %0h got %0h", want.stop_row, got.stop_row);
                        n_errors++;
                    end
                    if (got.tex_column !== want.tex_column) begin
                        $error("tex_column exp %0h got %0h", want.tex_column, got.tex_column);
                        n_errors++;
                    end
                    if (got.tex_step !== want.tex_step) begin
                        $error("tex_step exp %0h got %0h", want.tex_step, got.tex_step);
                        n_errors++;
                    end
                    if (got.tex_start !== want.tex_start) begin
                        $error("tex_start exp %0h got %0h", want.tex_start, got.tex_start);
                        n_errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_col(t_in_item c, logic has_slice, t_out_item typed);
        t_out_item p;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= c;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        p = predict_slice(c);
        if (p.tex_step == 32'hFFFF_FFFF) n_hzero++;
        pending_slices.push_back(has_slice ? typed : p);
        n_cols++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_slices.size() != 0) @(posedge i_clk);
    endtask

    t_col_row  col_rows[$];
    t_out_item fixed;
    int        phase_idle[4]  = '{0, 54, 0, 16};
    int        phase_stall[4] = '{0, 0, 54, 16};

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;

        // distance not positive: one LSB, tallest slice, rows clamp
        fixed = '{column_out: 12'd0, side_out: 2'd0, slice_height: 27'h200_0000,
                  first_row: 11'd0, stop_row: 11'd511, tex_column: 10'd0,
                  tex_step: 32'd0, tex_start: 32'd0};
        col_rows.push_back('{make_col(2'd0, 0, 0, 0, 0, 0, 0, 0, 0, 12'd0), 1'b1, fixed});
        // far wall: zero height, step saturates
        fixed = '{column_out: 12'hFFF, side_out: 2'd1, slice_height: 27'd0,
                  first_row: 11'd256, stop_row: 11'd256, tex_column: 10'd0,
                  tex_step: 32'hFFFF_FFFF, tex_start: 32'd0};
        col_rows.push_back('{make_col(2'd1, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0,
                                      12'hFFF), 1'b1, fixed});
        col_rows.push_back('{make_col(2'd2, 32'hFFFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      12'd5), 1'b0, fixed});
        col_rows.push_back('{make_col(2'd3, 0, 32'h0002_0000, 0, 32'h0001_0000,
                                      32'h8000_0000, 32'hFFFF_8000, 32'h0001_8000,
                                      0, 12'd6), 1'b0, fixed});
        col_rows.push_back('{make_col(2'd0, 32'h0003_0000, 0, 32'h0001_0000, 0,
                                      32'h0000_4000, 32'h0000_C000, 0, 32'h0002_4000,
                                      12'd7), 1'b0, fixed});
        col_rows.push_back('{make_col(2'd2, 32'h0003_0000, 0, 32'h0001_0000, 0, 0,
                                      32'hFFFF_4000, 0, 32'h0002_4000, 12'd8), 1'b0, fixed});
        col_rows.push_back('{make_col(2'd1, 0, 32'h0001_0000, 0, 32'h0001_0000,
                                      32'h0000_8000, 32'h0000_8000, 32'h0000_1000, 0,
                                      12'd9), 1'b0, fixed});
        col_rows.push_back('{make_col(2'd3, 0, 32'h0001_0001, 0, 32'h0001_0000,
                                      32'h0000_8000, 32'hFFFF_0000, 32'h0000_1000, 0,
                                      12'd10), 1'b0, fixed});
        col_rows.push_back('{make_col(2'd0, 32'h0200_0000, 0, 0, 0, 32'h0001_0000,
                                      32'h0001_0000, 0, 0, 12'd11), 1'b0, fixed});
        col_rows.push_back('{make_col(2'd2, 32'h0000_8000, 0, 0, 0, 32'hFFFF_0000,
                                      32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                                      12'h555), 1'b0, fixed});
        col_rows.push_back('{make_col(2'd1, 0, 32'hAAAA_AAAA, 0, 32'h5555_5555,
                                      32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                      32'h5555_5555, 12'hAAA), 1'b0, fixed});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (col_rows[i])
            send_col(col_rows[i].col_item, col_rows[i].has_slice, col_rows[i].slice);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                send_col(rand_col(), 1'b0, fixed);
                if (k == 100) drain();
            end
            drain();
        end
        stall_pct = 0;

        repeat (3 * PIPE_LEN) @(posedge i_clk);
        $display("covered %0d columns and %0d slices, %0d with zero height",
                 n_cols, n_slices, n_hzero);
        $display("idle and stall mixes: none, sender, receiver, both");
        if (n_errors == 0 && pending_slices.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
